// ----- rtl/acpp_pkg.sv -----
// ----------------------------------------------------------------------------
// acpp_pkg
// Shared types and constants of the caption packet parser.
// ----------------------------------------------------------------------------
package acpp_pkg;

   localparam int WordWidth    = 10;
   localparam int ByteWidth    = 8;
   localparam int CaptionWidth = 16;
   localparam int StatusWidth  = 2;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 10;
   localparam int TripWidth    = 5;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CAPTION_DID    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_CAPTION_SDID   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FIELD_ONE_TYPE = 2'd2;

   localparam logic [WordWidth-1:0] RST_CAPTION_DID    = 10'h161;
   localparam logic [WordWidth-1:0] RST_CAPTION_SDID   = 10'h101;
   localparam logic [ByteWidth-1:0] RST_FIELD_ONE_TYPE = 8'hFC;

   // result status codes
   localparam logic [StatusWidth-1:0] ST_FOUND     = 2'd0;
   localparam logic [StatusWidth-1:0] ST_NO_FIELD1 = 2'd1;
   localparam logic [StatusWidth-1:0] ST_NO_PACKET = 2'd2;

   // ancillary framing and packet constants
   localparam logic [WordWidth-1:0] ADF_ZERO  = 10'h000;
   localparam logic [WordWidth-1:0] ADF_ONES  = 10'h3FF;
   localparam logic [ByteWidth-1:0] HDR_ID0   = 8'h96;
   localparam logic [ByteWidth-1:0] HDR_ID1   = 8'h69;
   localparam logic [ByteWidth-1:0] DATA_MARK = 8'h72;
   localparam logic [ByteWidth-1:0] TC_FLAG_POS  = 8'd4;
   localparam logic [ByteWidth-1:0] MARK_POS     = 8'd7;
   localparam logic [ByteWidth-1:0] MARK_POS_TC  = 8'd12;

   typedef enum logic [2:0] {
      PH_START,
      PH_ADF1,
      PH_ADF2,
      PH_DID,
      PH_SDID,
      PH_COUNT,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic [WordWidth-1:0] caption_did;
      logic [WordWidth-1:0] caption_sdid;
      logic [ByteWidth-1:0] field_one_type;
   } cfg_type;

   typedef struct packed {
      logic [StatusWidth-1:0]  status;
      logic [CaptionWidth-1:0] caption_word;
   } result_type;

endpackage

// ----- rtl/acpp_if.sv -----
// ----------------------------------------------------------------------------
// acpp interfaces
// Valid/ready channels for words in, results out and register writes.
// ----------------------------------------------------------------------------
interface acpp_req_if;
   logic                               valid;
   logic                               ready;
   logic [acpp_pkg::WordWidth-1:0]     data_word;
   logic                               line_end;

   modport source (output valid, output data_word, output line_end, input ready);
   modport sink   (input valid, input data_word, input line_end, output ready);
endinterface

interface acpp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [acpp_pkg::StatusWidth-1:0]   status;
   logic [acpp_pkg::CaptionWidth-1:0]  caption_word;

   modport source (output valid, output status, output caption_word, input ready);
   modport sink   (input valid, input status, input caption_word, output ready);
endinterface

interface acpp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [acpp_pkg::CsrIdxWidth-1:0]   index;
   logic [acpp_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/acpp_csr.sv -----
// ----------------------------------------------------------------------------
// acpp_csr
// Configuration registers: caption DID, SDID and field-one type byte.
// ----------------------------------------------------------------------------
module acpp_csr (
   input  logic              clock,
   input  logic              reset,
   acpp_csr_if.sink          csr_bus,
   output acpp_pkg::cfg_type cfg
);

   acpp_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            acpp_pkg::CSR_CAPTION_DID:    cfg_in.caption_did    = csr_bus.data;
            acpp_pkg::CSR_CAPTION_SDID:   cfg_in.caption_sdid   = csr_bus.data;
            acpp_pkg::CSR_FIELD_ONE_TYPE:
               cfg_in.field_one_type = csr_bus.data[acpp_pkg::ByteWidth-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.caption_did    <= acpp_pkg::RST_CAPTION_DID;
         cfg_ff.caption_sdid   <= acpp_pkg::RST_CAPTION_SDID;
         cfg_ff.field_one_type <= acpp_pkg::RST_FIELD_ONE_TYPE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/acpp_parse.sv -----
// ----------------------------------------------------------------------------
// acpp_parse
// Line parser state machine: flag, DID/SDID, count, payload scan, verdict.
// ----------------------------------------------------------------------------
module acpp_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [acpp_pkg::WordWidth-1:0]   data_word,
   input  logic                             line_end,
   input  acpp_pkg::cfg_type                cfg,
   output logic                             res_valid,
   output acpp_pkg::result_type             res
);

   localparam int BW = acpp_pkg::ByteWidth;
   localparam int WW = acpp_pkg::WordWidth;
   localparam int TW = acpp_pkg::TripWidth;

   acpp_pkg::phase_type phase_ff, phase_in;
   logic [WW-1:0] did_ff, did_in, sdid_ff, sdid_in;
   logic [BW-1:0] len_ff, len_in, idx_ff, idx_in;
   logic          hdr_ok_ff, hdr_ok_in, tc_ff, tc_in;
   logic [TW-1:0] tlim_ff, tlim_in, tnum_ff, tnum_in;
   logic [1:0]    tph_ff, tph_in;
   logic          hit_ff, hit_in, found_ff, found_in, done_ff, done_in;
   logic [acpp_pkg::CaptionWidth-1:0] held_ff, held_in;

   logic [BW-1:0] byte_val, mark, mark_p1, need;

   assign byte_val = data_word[BW-1:0];
   assign mark     = tc_ff ? acpp_pkg::MARK_POS_TC : acpp_pkg::MARK_POS;
   assign mark_p1  = mark + 8'd1;
   assign need     = mark_p1;

   always_comb begin
      phase_in  = phase_ff;
      did_in    = did_ff;
      sdid_in   = sdid_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      hdr_ok_in = hdr_ok_ff;
      tc_in     = tc_ff;
      tlim_in   = tlim_ff;
      tnum_in   = tnum_ff;
      tph_in    = tph_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      held_in   = held_ff;
      done_in   = done_ff;
      res_valid = 1'b0;
      res.status       = acpp_pkg::ST_NO_PACKET;
      res.caption_word = '0;

      if (!done_ff) begin
         unique case (phase_ff)
            acpp_pkg::PH_START: begin
               if (data_word == acpp_pkg::ADF_ZERO) begin
                  phase_in = acpp_pkg::PH_ADF1;
               end else begin
                  res_valid = 1'b1;
                  done_in   = 1'b1;
               end
            end
            acpp_pkg::PH_ADF1: begin
               phase_in = (data_word == acpp_pkg::ADF_ONES) ? acpp_pkg::PH_ADF2
                                                            : acpp_pkg::PH_START;
            end
            acpp_pkg::PH_ADF2: begin
               phase_in = (data_word == acpp_pkg::ADF_ONES) ? acpp_pkg::PH_DID
                                                            : acpp_pkg::PH_START;
            end
            acpp_pkg::PH_DID: begin
               did_in   = data_word;
               phase_in = acpp_pkg::PH_SDID;
            end
            acpp_pkg::PH_SDID: begin
               sdid_in  = data_word;
               phase_in = acpp_pkg::PH_COUNT;
            end
            acpp_pkg::PH_COUNT: begin
               len_in    = byte_val;
               idx_in    = '0;
               hdr_ok_in = 1'b1;
               tc_in     = 1'b0;
               tlim_in   = '0;
               tnum_in   = '0;
               tph_in    = '0;
               hit_in    = 1'b0;
               found_in  = 1'b0;
               held_in   = '0;
               phase_in  = (byte_val == '0) ? acpp_pkg::PH_CHECK : acpp_pkg::PH_PAYLOAD;
            end
            acpp_pkg::PH_PAYLOAD: begin
               if (idx_ff == 8'd0 && byte_val != acpp_pkg::HDR_ID0) hdr_ok_in = 1'b0;
               if (idx_ff == 8'd1 && byte_val != acpp_pkg::HDR_ID1) hdr_ok_in = 1'b0;
               if (idx_ff == acpp_pkg::TC_FLAG_POS) tc_in = byte_val[BW-1];
               if (idx_ff == mark && byte_val != acpp_pkg::DATA_MARK) hdr_ok_in = 1'b0;
               if (idx_ff == mark_p1) tlim_in = byte_val[TW-1:0];
               // triplet scan: type byte, first caption byte, second caption byte
               if (idx_ff > mark_p1 && !found_ff && tnum_ff < tlim_ff) begin
                  priority case (tph_ff)
                     2'd0: begin
                        hit_in = (byte_val == cfg.field_one_type);
                        tph_in = 2'd1;
                     end
                     2'd1: begin
                        if (hit_ff) held_in = {{BW{1'b0}}, byte_val};
                        tph_in = 2'd2;
                     end
                     default: begin
                        if (hit_ff) begin
                           held_in  = {byte_val, held_ff[BW-1:0]};
                           found_in = 1'b1;
                        end
                        tnum_in = tnum_ff + 5'd1;
                        tph_in  = 2'd0;
                     end
                  endcase
               end
               idx_in = idx_ff + 8'd1;
               if (idx_in >= len_ff) phase_in = acpp_pkg::PH_CHECK;
            end
            acpp_pkg::PH_CHECK: begin
               if (did_ff == cfg.caption_did && sdid_ff == cfg.caption_sdid &&
                   hdr_ok_ff && len_ff >= need) begin
                  res_valid        = 1'b1;
                  res.status       = found_ff ? acpp_pkg::ST_FOUND : acpp_pkg::ST_NO_FIELD1;
                  res.caption_word = found_ff ? held_ff : '0;
                  done_in          = 1'b1;
               end else begin
                  phase_in = acpp_pkg::PH_START;
               end
            end
         endcase
      end

      // end of line: give up if nothing reported yet, then back to reset values
      if (line_end) begin
         if (!done_in) begin
            res_valid        = 1'b1;
            res.status       = acpp_pkg::ST_NO_PACKET;
            res.caption_word = '0;
         end
         phase_in  = acpp_pkg::PH_START;
         did_in    = '0;
         sdid_in   = '0;
         len_in    = '0;
         idx_in    = '0;
         hdr_ok_in = 1'b1;
         tc_in     = 1'b0;
         tlim_in   = '0;
         tnum_in   = '0;
         tph_in    = '0;
         hit_in    = 1'b0;
         found_in  = 1'b0;
         held_in   = '0;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= acpp_pkg::PH_START;
         did_ff    <= '0;
         sdid_ff   <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         hdr_ok_ff <= 1'b1;
         tc_ff     <= 1'b0;
         tlim_ff   <= '0;
         tnum_ff   <= '0;
         tph_ff    <= '0;
         hit_ff    <= 1'b0;
         found_ff  <= 1'b0;
         held_ff   <= '0;
         done_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         did_ff    <= did_in;
         sdid_ff   <= sdid_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         hdr_ok_ff <= hdr_ok_in;
         tc_ff     <= tc_in;
         tlim_ff   <= tlim_in;
         tnum_ff   <= tnum_in;
         tph_ff    <= tph_in;
         hit_ff    <= hit_in;
         found_ff  <= found_in;
         held_ff   <= held_in;
         done_ff   <= done_in;
      end
   end

   // at most one result per line: once reported, the rest of the line is silent
   a_one_per_line: assert property (@(posedge clock) disable iff (reset)
      done_ff && step && !line_end |-> !res_valid)
      else $error("second result on one line");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && line_end |=> phase_ff == acpp_pkg::PH_START && !done_ff)
      else $error("state not cleared after line end");

   a_word_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != acpp_pkg::ST_FOUND |-> res.caption_word == '0)
      else $error("caption word set without a capture");

endmodule

// ----- rtl/acpp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// acpp_out_fifo
// Two-entry result queue driving the result channel.
// ----------------------------------------------------------------------------
module acpp_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  acpp_pkg::result_type push_data,
   output logic                 full,
   acpp_rsp_if.source           rsp_bus
);

   acpp_pkg::result_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       pop;

   assign full                 = (count_ff == 2'd2);
   assign rsp_bus.valid        = (count_ff != 2'd0);
   assign rsp_bus.status       = mem_ff[rd_ptr_ff].status;
   assign rsp_bus.caption_word = mem_ff[rd_ptr_ff].caption_word;
   assign pop                  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = ~wr_ptr_ff;
      if (pop)  rd_ptr_in = ~rd_ptr_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full result queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 || count_ff == 2'd2 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

// ----- rtl/anc_caption_packet_parser_top.sv -----
// ----------------------------------------------------------------------------
// anc_caption_packet_parser_top
// Path: the item that decides a result is registered in the input stage, then
//   parsed into the result queue, from which rsp presents it.
// Throughput: one item per cycle; req stalls only when the two-entry result
//   queue is full and the held item is waiting on it.
// Reset: synchronous, active high; registers return to their reset values,
//   the parser to the start of a line, queue and input stage empty.
// ----------------------------------------------------------------------------
module anc_caption_packet_parser_top (
   input  logic        clock,
   input  logic        reset,
   acpp_req_if.sink    req_bus,
   acpp_rsp_if.source  rsp_bus,
   acpp_csr_if.sink    csr_bus
);

   // input stage: one word held for the parser
   logic                           in_vld_ff, in_vld_in;
   logic [acpp_pkg::WordWidth-1:0] in_word_ff;
   logic                           in_last_ff;
   logic                           accept;
   logic                           step;

   // between parser and result queue
   logic                           res_valid;
   acpp_pkg::result_type           res;
   logic                           q_full;
   acpp_pkg::cfg_type              cfg;

   // The parser consumes the held word whenever the queue has room; words
   // that give no result still wait on a full queue, which keeps order simple.
   assign step          = in_vld_ff && !q_full;
   assign req_bus.ready = !in_vld_ff || step;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept)    in_vld_in = 1'b1;
      else if (step) in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // payload of the input stage, loaded on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_bus.data_word;
         in_last_ff <= req_bus.line_end;
      end
   end

   // caption DID/SDID and field-one type byte
   acpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // line state machine; one word per step
   acpp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_word (in_word_ff),
      .line_end  (in_last_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // result queue decouples the parser from rsp back-pressure
   acpp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_data (res),
      .full      (q_full),
      .rsp_bus   (rsp_bus)
   );

   a_step_needs_item: assert property (@(posedge clock) disable iff (reset)
      step |-> in_vld_ff)
      else $error("parser stepped without a held item");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !step |=> in_vld_ff && $stable(in_word_ff) && $stable(in_last_ff))
      else $error("held item lost while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_bus.ready)
      else $error("input not ready with empty stage");

endmodule

// ----- sim/anc_caption_packet_parser_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anc_caption_packet_parser_top_test
// Feeds ancillary lines word by word into the caption packet parser and checks
// every result against an in-bench line parser model, across several register
// settings and with random idling on the word and result channels.
// ----------------------------------------------------------------------------
module anc_caption_packet_parser_top_test;

   // index past the last register; writes there must be dropped
   localparam logic [acpp_pkg::CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;
   localparam int NumPhases = 6;
   localparam int PhaseWords = 240;
   // margin after the last result is in, so that the pipeline is empty
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic [acpp_pkg::WordWidth-1:0] word;
      logic                           last;
   } anc_word_type;

   logic clock;
   logic reset;

   acpp_req_if req_if ();
   acpp_rsp_if rsp_if ();
   acpp_csr_if csr_if ();

   anc_caption_packet_parser_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // words waiting to be sent, results still owed by the block
   anc_word_type         word_q[$];
   acpp_pkg::result_type caption_expect_q[$];
   acpp_pkg::result_type expected_result;

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatch_count;
   int pause_count;
   bit hold_off;

   // ------------------------------------------------------------------------
   // Line parser model: register copy and per-line parse state
   // ------------------------------------------------------------------------
   acpp_pkg::cfg_type                     cfg;
   acpp_pkg::phase_type                   parse_phase;
   logic [acpp_pkg::WordWidth-1:0]        seen_did;
   logic [acpp_pkg::WordWidth-1:0]        seen_sdid;
   logic [acpp_pkg::ByteWidth-1:0]        payload_len;
   logic [acpp_pkg::ByteWidth-1:0]        byte_pos;
   logic                                  hdr_ok;
   logic                                  tc_flag;
   logic [acpp_pkg::TripWidth-1:0]        trip_limit;
   logic [acpp_pkg::TripWidth-1:0]        trip_num;
   logic [1:0]                            trip_phase;
   logic                                  type_hit;
   logic                                  found;
   logic [acpp_pkg::CaptionWidth-1:0]     held_caption;
   logic                                  line_done;

   function automatic void clear_packet_state();
      payload_len  = '0;
      byte_pos     = '0;
      hdr_ok       = 1'b1;
      tc_flag      = 1'b0;
      trip_limit   = '0;
      trip_num     = '0;
      trip_phase   = '0;
      type_hit     = 1'b0;
      found        = 1'b0;
      held_caption = '0;
   endfunction

   function automatic void clear_line_state();
      parse_phase = acpp_pkg::PH_START;
      seen_did    = '0;
      seen_sdid   = '0;
      clear_packet_state();
      line_done   = 1'b0;
   endfunction

   function automatic void push_caption_expect(
         input logic [acpp_pkg::StatusWidth-1:0]  st,
         input logic [acpp_pkg::CaptionWidth-1:0] cw);
      acpp_pkg::result_type r;
      r.status       = st;
      r.caption_word = cw;
      caption_expect_q.push_back(r);
   endfunction

   // advance the model by one accepted word
   function automatic void parse_anc_word(input logic [acpp_pkg::WordWidth-1:0] dw,
                                          input logic last);
      logic [acpp_pkg::ByteWidth-1:0] b;
      int mark;
      b = dw[acpp_pkg::ByteWidth-1:0];
      // data marker position; also one less than the minimum payload length
      mark = tc_flag ? int'(acpp_pkg::MARK_POS_TC) : int'(acpp_pkg::MARK_POS);
      if (!line_done) begin
         case (parse_phase)
            acpp_pkg::PH_ADF1: begin
               parse_phase = (dw == acpp_pkg::ADF_ONES) ? acpp_pkg::PH_ADF2
                                                        : acpp_pkg::PH_START;
            end
            acpp_pkg::PH_ADF2: begin
               parse_phase = (dw == acpp_pkg::ADF_ONES) ? acpp_pkg::PH_DID
                                                        : acpp_pkg::PH_START;
            end
            acpp_pkg::PH_DID: begin
               seen_did    = dw;
               parse_phase = acpp_pkg::PH_SDID;
            end
            acpp_pkg::PH_SDID: begin
               seen_sdid   = dw;
               parse_phase = acpp_pkg::PH_COUNT;
            end
            acpp_pkg::PH_COUNT: begin
               clear_packet_state();
               payload_len = b;
               parse_phase = (b == '0) ? acpp_pkg::PH_CHECK : acpp_pkg::PH_PAYLOAD;
            end
            acpp_pkg::PH_PAYLOAD: begin
               if (byte_pos == 0 && b != acpp_pkg::HDR_ID0) hdr_ok = 1'b0;
               if (byte_pos == 1 && b != acpp_pkg::HDR_ID1) hdr_ok = 1'b0;
               if (byte_pos == acpp_pkg::TC_FLAG_POS) tc_flag = b[7];
               if (byte_pos == mark && b != acpp_pkg::DATA_MARK) hdr_ok = 1'b0;
               if (byte_pos == mark + 1) trip_limit = b[acpp_pkg::TripWidth-1:0];
               // cc triplets: type, first byte, second byte
               if (byte_pos > mark + 1 && !found && trip_num < trip_limit) begin
                  case (trip_phase)
                     2'd0: begin
                        type_hit   = (b == cfg.field_one_type);
                        trip_phase = 2'd1;
                     end
                     2'd1: begin
                        if (type_hit) held_caption = {8'h00, b};
                        trip_phase = 2'd2;
                     end
                     default: begin
                        if (type_hit) begin
                           held_caption = {b, held_caption[7:0]};
                           found        = 1'b1;
                        end
                        trip_num   = trip_num + 1'b1;
                        trip_phase = 2'd0;
                     end
                  endcase
               end
               byte_pos = byte_pos + 1'b1;
               if (byte_pos >= payload_len) parse_phase = acpp_pkg::PH_CHECK;
            end
            acpp_pkg::PH_CHECK: begin
               if (seen_did == cfg.caption_did && seen_sdid == cfg.caption_sdid &&
                   hdr_ok && int'(payload_len) >= mark + 1) begin
                  if (found) push_caption_expect(acpp_pkg::ST_FOUND, held_caption);
                  else push_caption_expect(acpp_pkg::ST_NO_FIELD1, '0);
                  line_done = 1'b1;
               end else begin
                  parse_phase = acpp_pkg::PH_START;
               end
            end
            default: begin
               if (dw == acpp_pkg::ADF_ZERO) begin
                  parse_phase = acpp_pkg::PH_ADF1;
               end else begin
                  push_caption_expect(acpp_pkg::ST_NO_PACKET, '0);
                  line_done = 1'b1;
               end
            end
         endcase
      end
      if (last) begin
         if (!line_done) push_caption_expect(acpp_pkg::ST_NO_PACKET, '0);
         clear_line_state();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------------
   function automatic void add_line(input logic [acpp_pkg::WordWidth-1:0] words[$]);
      anc_word_type w;
      for (int i = 0; i < words.size(); i++) begin
         w.word = words[i];
         w.last = (i == words.size() - 1);
         word_q.push_back(w);
      end
   endfunction

   // one random line, mostly well-formed caption packets; returns its length
   function automatic int build_caption_line();
      logic [acpp_pkg::WordWidth-1:0] line[$];
      logic [acpp_pkg::ByteWidth-1:0] body[$];
      logic [acpp_pkg::ByteWidth-1:0] ty;
      int n_pkt;
      int n_trip;
      int count;
      int cut;
      int p;
      int k;
      bit tc;
      line.delete();
      if ($urandom_range(11) == 0) begin
         // noise line: random words, often a bad start word
         repeat ($urandom_range(1, 4)) line.push_back(acpp_pkg::WordWidth'($urandom));
      end else begin
         n_pkt = ($urandom_range(5) == 0) ? 2 : 1;
         for (p = 0; p < n_pkt; p++) begin
            body.delete();
            tc = ($urandom_range(2) == 0);
            body.push_back(acpp_pkg::HDR_ID0);
            body.push_back(acpp_pkg::HDR_ID1);
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            body.push_back({tc, 7'($urandom)});
            body.push_back(8'($urandom));
            body.push_back(8'($urandom));
            if (tc) repeat (5) body.push_back(8'($urandom));
            body.push_back(acpp_pkg::DATA_MARK);
            n_trip = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(5);
            body.push_back({3'($urandom), 5'(n_trip)});
            repeat (n_trip) begin
               case ($urandom_range(3))
                  0, 1: ty = cfg.field_one_type;
                  2: ty = cfg.field_one_type ^ (8'h01 << $urandom_range(7));
                  default: ty = 8'($urandom);
               endcase
               // make field-one hits land on later triplets as well
               if ($urandom_range(1) == 0 && ty == cfg.field_one_type) ty = ty ^ 8'h01;
               body.push_back(ty);
               body.push_back(8'($urandom));
               body.push_back(8'($urandom));
            end
            repeat ($urandom_range(3)) body.push_back(8'($urandom));
            // broken header: header id, time code flag or data marker
            if ($urandom_range(7) == 0) begin
               case ($urandom_range(3))
                  0: k = 0;
                  1: k = 1;
                  2: k = acpp_pkg::TC_FLAG_POS;
                  default: k = tc ? acpp_pkg::MARK_POS_TC : acpp_pkg::MARK_POS;
               endcase
               body[k] = body[k] ^ (8'h01 << $urandom_range(7));
            end
            count = body.size();
            if ($urandom_range(7) == 0) begin
               count = $urandom_range(body.size() - 1);
               while (body.size() > count) void'(body.pop_back());
            end
            line.push_back(($urandom_range(15) == 0) ? acpp_pkg::WordWidth'($urandom)
                                                     : acpp_pkg::ADF_ZERO);
            line.push_back(($urandom_range(15) == 0) ? acpp_pkg::WordWidth'($urandom)
                                                     : acpp_pkg::ADF_ONES);
            line.push_back(($urandom_range(15) == 0) ? acpp_pkg::WordWidth'($urandom)
                                                     : acpp_pkg::ADF_ONES);
            line.push_back(($urandom_range(7) == 0) ? acpp_pkg::WordWidth'($urandom)
                                                    : cfg.caption_did);
            line.push_back(($urandom_range(7) == 0) ? acpp_pkg::WordWidth'($urandom)
                                                    : cfg.caption_sdid);
            line.push_back({2'($urandom), 8'(count)});
            for (k = 0; k < body.size(); k++) line.push_back({2'($urandom), body[k]});
            line.push_back(acpp_pkg::WordWidth'($urandom));
         end
         repeat ($urandom_range(2)) line.push_back(acpp_pkg::WordWidth'($urandom));
         // line cut short anywhere
         if ($urandom_range(7) == 0) begin
            cut = $urandom_range(1, line.size());
            while (line.size() > cut) void'(line.pop_back());
         end
      end
      add_line(line);
      return line.size();
   endfunction

   // ------------------------------------------------------------------------
   // Register writes; only issued while the block is idle
   // ------------------------------------------------------------------------
   task automatic write_reg(input logic [acpp_pkg::CsrIdxWidth-1:0]  idx,
                            input logic [acpp_pkg::CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         acpp_pkg::CSR_CAPTION_DID:    cfg.caption_did    = value;
         acpp_pkg::CSR_CAPTION_SDID:   cfg.caption_sdid   = value;
         acpp_pkg::CSR_FIELD_ONE_TYPE:
            cfg.field_one_type = value[acpp_pkg::ByteWidth-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Word driver: holds valid until the item is taken, predicts on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            parse_anc_word(req_if.data_word, req_if.line_end);
            // after a line end, now and then wait for the block to empty out
            if (req_if.line_end && (pause_count == 0 || $urandom_range(7) == 0)) begin
               hold_off = 1'b1;
               pause_count++;
            end
         end
         if (hold_off && caption_expect_q.size() == 0) hold_off = 1'b0;
         if (!req_if.valid || req_if.ready) begin
            if (word_q.size() > 0 && !hold_off &&
                $urandom_range(99) >= send_idle_pct) begin
               req_if.valid     <= 1'b1;
               req_if.data_word <= word_q[0].word;
               req_if.line_end  <= word_q[0].last;
               void'(word_q.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: random back-pressure, in-order compare
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (caption_expect_q.size() == 0) begin
               $error("unexpected result: status %0d caption_word 0x%04h",
                      rsp_if.status, rsp_if.caption_word);
               mismatch_count++;
            end else begin
               expected_result = caption_expect_q.pop_front();
               if (rsp_if.status !== expected_result.status) begin
                  $error("status: expected %0d, actual %0d",
                         expected_result.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.caption_word !== expected_result.caption_word) begin
                  $error("caption_word: expected 0x%04h, actual 0x%04h",
                         expected_result.caption_word, rsp_if.caption_word);
                  mismatch_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: reset, then phases of register setting, stimulus and drain
   // ------------------------------------------------------------------------
   initial begin
      int phase_words;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_word = '0;
      req_if.line_end  = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = '0;
      csr_if.data      = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      mismatch_count   = 0;
      pause_count      = 0;
      hold_off         = 1'b0;
      cfg.caption_did    = acpp_pkg::RST_CAPTION_DID;
      cfg.caption_sdid   = acpp_pkg::RST_CAPTION_SDID;
      cfg.field_one_type = acpp_pkg::RST_FIELD_ONE_TYPE;
      clear_line_state();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NumPhases; phase++) begin
         // idling mode: none, sender, receiver, both
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase

         // phase 0 runs on the reset values
         case (phase)
            1: begin
               write_reg(acpp_pkg::CSR_CAPTION_DID, 10'h3FF);
               write_reg(acpp_pkg::CSR_CAPTION_SDID, 10'h3FF);
               write_reg(acpp_pkg::CSR_FIELD_ONE_TYPE, 10'h3FF);
            end
            2: begin
               write_reg(acpp_pkg::CSR_CAPTION_DID, 10'h000);
               write_reg(acpp_pkg::CSR_CAPTION_SDID, 10'h000);
               write_reg(acpp_pkg::CSR_FIELD_ONE_TYPE, 10'h000);
            end
            3, 4: begin
               write_reg(acpp_pkg::CSR_CAPTION_DID, acpp_pkg::CsrDataWidth'($urandom));
               write_reg(acpp_pkg::CSR_CAPTION_SDID, acpp_pkg::CsrDataWidth'($urandom));
               write_reg(acpp_pkg::CSR_FIELD_ONE_TYPE, acpp_pkg::CsrDataWidth'($urandom));
            end
            5: begin
               write_reg(acpp_pkg::CSR_FIELD_ONE_TYPE,
                         {2'b10, acpp_pkg::RST_FIELD_ONE_TYPE});
               write_reg(acpp_pkg::CSR_CAPTION_SDID, acpp_pkg::RST_CAPTION_SDID);
               write_reg(acpp_pkg::CSR_CAPTION_DID, acpp_pkg::RST_CAPTION_DID);
            end
            default: ;
         endcase
         // a write to the unused index must not disturb anything
         if (phase > 0) write_reg(CSR_UNUSED, acpp_pkg::CsrDataWidth'($urandom));

         phase_words = 0;
         if (phase == 0) begin
            // bad start word together with the line end
            add_line('{10'h001});
            // empty payload; rejected, then the line end gives no packet
            add_line('{acpp_pkg::ADF_ZERO, acpp_pkg::ADF_ONES, acpp_pkg::ADF_ONES,
                       10'h161, 10'h101, 10'h000, 10'h3FF});
            // one field-one triplet: caption 0x4241
            add_line('{acpp_pkg::ADF_ZERO, acpp_pkg::ADF_ONES, acpp_pkg::ADF_ONES,
                       10'h161, 10'h101, 10'h00C,
                       10'h096, 10'h069, 10'h04F, 10'h043, 10'h000, 10'h01B, 10'h02C,
                       10'h072, 10'h0E1, 10'h0FC, 10'h041, 10'h042, 10'h2A5});
            phase_words = 27;
         end
         while (phase_words < PhaseWords) phase_words += build_caption_line();

         // drain: all words sent, all results in, pipeline empty
         while (word_q.size() > 0 || req_if.valid) @(posedge clock);
         while (caption_expect_q.size() > 0) @(posedge clock);
         repeat (DrainCycles) @(posedge clock);
      end

      if (mismatch_count == 0 && caption_expect_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
